[rtl/core/arsc_pkg.sv]
`timescale 1ns / 1ps

package arsc_pkg;

    // Sizes of the array description and of the arithmetic.
    localparam int MAX_DIMS    = 8;
    localparam int DIM_W       = $clog2(MAX_DIMS);
    localparam int CNT_W       = $clog2(MAX_DIMS + 1);
    localparam int EXTENT_BITS = 16;
    localparam int AXIS_W      = 3;
    localparam int VOL_W       = 48;
    localparam int INC_W       = VOL_W + 1;
    localparam int PROD_W      = VOL_W + EXTENT_BITS;

    // Error codes carried on the result.
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_AXIS = 2'd1,
        ERR_OVF  = 2'd2
    } err_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_FILL,
        ST_VINIT,
        ST_VOL,
        ST_OUT_RD,
        ST_OUT_EM,
        ST_ERR
    } state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic             load_en;
        logic [DIM_W-1:0] load_idx;
        logic             ord_en;
        logic [DIM_W-1:0] ord_idx;
        logic             perm_wr;
        logic [DIM_W-1:0] perm_idx;
        logic [DIM_W-1:0] perm_val;
        logic             vinit;
        logic             vol_en;
        logic             out_rd;
        logic             out_em;
        logic             err_em;
        logic [CNT_W-1:0] k;
        logic             out_last;
        logic [CNT_W-1:0] first;
        err_t             err_code;
    } ctrl_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic [AXIS_W-1:0] order_ax;
        logic              prod_ovf;
        logic              moved;
    } status_t;

endpackage

[rtl/core/axis_reorder_stride_calc_top.sv]
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     start / busy         extent, order_axis, order_given, last_axis
// result    result_valid strobe  new_extent, increment, first_moved, error, last_result
//
// An item without last_axis is loaded and busy stays low.
// After the last axis: order checks, then appending the unnamed axes, seeding
// the volumes, prefix products on the shared multiplier, then per result a
// volume read, then the subtract.
// An error result comes after the failing check instead of the result walk.
// Reset clears the sequencer and the strobe; results cannot be stalled.
module axis_reorder_stride_calc_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [arsc_pkg::EXTENT_BITS-1:0]    extent,
    input  logic [arsc_pkg::AXIS_W-1:0]         order_axis,
    input  logic                                order_given,
    input  logic                                last_axis,
    output logic                                result_valid,
    output logic [15:0]                         new_extent,
    output logic signed [arsc_pkg::INC_W-1:0]   increment,
    output logic [3:0]                          first_moved,
    output logic [1:0]                          error,
    output logic                                last_result
);
    import arsc_pkg::*;

    ctrl_t   ctrl;
    status_t stat;

    // Sequencer with counters and check flags.
    arsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .order_given (order_given),
        .last_axis   (last_axis),
        .stat        (stat),
        .busy        (busy),
        .ctrl        (ctrl)
    );

    // Stores, shared multiplier, volume memory and result registers.
    arsc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .extent       (extent),
        .order_axis   (order_axis),
        .stat         (stat),
        .result_valid (result_valid),
        .new_extent   (new_extent),
        .increment    (increment),
        .first_moved  (first_moved),
        .error        (error),
        .last_result  (last_result)
    );

endmodule

[rtl/core/arsc_ctrl.sv]
`timescale 1ns / 1ps

module arsc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             order_given,
    input  logic             last_axis,
    input  arsc_pkg::status_t stat,
    output logic             busy,
    output arsc_pkg::ctrl_t  ctrl
);
    import arsc_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     ax_cnt_reg, ax_cnt_next;
    logic [CNT_W-1:0]     ord_cnt_reg, ord_cnt_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     ng_reg, ng_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     p_reg, p_next;
    logic [CNT_W-1:0]     first_reg, first_next;
    logic [MAX_DIMS-1:0]  used_reg, used_next;
    logic                 ovf_reg, ovf_next;
    err_t                 err_reg, err_next;

    logic accept;
    logic room_ax;
    logic room_ord;
    logic take_ord;
    logic bad_axis;
    logic k_at_n;
    logic k_at_ng;
    logic k_last;

    // Transaction acceptance and the conditions the sequencer branches on.
    assign busy     = (state_reg != ST_LOAD);
    assign accept   = start && !busy;
    assign room_ax  = (ax_cnt_reg < CNT_W'(MAX_DIMS));
    assign room_ord = (ord_cnt_reg < CNT_W'(MAX_DIMS));
    assign take_ord = order_given && room_ax && room_ord;
    assign bad_axis = (CNT_W'(stat.order_ax) >= n_reg) || used_reg[stat.order_ax];
    assign k_at_n   = (k_reg == n_reg);
    assign k_at_ng  = (k_reg == ng_reg);
    assign k_last   = ((k_reg + 1'b1) == n_reg);

    // State register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            ax_cnt_reg  <= '0;
            ord_cnt_reg <= '0;
            n_reg       <= '0;
            ng_reg      <= '0;
            k_reg       <= '0;
            p_reg       <= '0;
            first_reg   <= '0;
            used_reg    <= '0;
            ovf_reg     <= 1'b0;
            err_reg     <= ERR_NONE;
        end
        else
        begin
            state_reg   <= state_next;
            ax_cnt_reg  <= ax_cnt_next;
            ord_cnt_reg <= ord_cnt_next;
            n_reg       <= n_next;
            ng_reg      <= ng_next;
            k_reg       <= k_next;
            p_reg       <= p_next;
            first_reg   <= first_next;
            used_reg    <= used_next;
            ovf_reg     <= ovf_next;
            err_reg     <= err_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && last_axis)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (k_at_ng)
                    state_next = ST_FILL;
                else if (bad_axis)
                    state_next = ST_ERR;
            end
            ST_FILL:
            begin
                if (k_at_n)
                    state_next = ST_VINIT;
            end
            ST_VINIT:
                state_next = ST_VOL;
            ST_VOL:
            begin
                if (k_at_n)
                    state_next = ovf_reg ? ST_ERR : ST_OUT_RD;
            end
            ST_OUT_RD:
                state_next = ST_OUT_EM;
            ST_OUT_EM:
                state_next = k_last ? ST_LOAD : ST_OUT_RD;
            ST_ERR:
                state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Counter updates and datapath commands.
    always_comb
    begin
        ax_cnt_next   = ax_cnt_reg;
        ord_cnt_next  = ord_cnt_reg;
        n_next        = n_reg;
        ng_next       = ng_reg;
        k_next        = k_reg;
        p_next        = p_reg;
        first_next    = first_reg;
        used_next     = used_reg;
        ovf_next      = ovf_reg;
        err_next      = err_reg;

        ctrl          = '0;
        ctrl.load_idx = ax_cnt_reg[DIM_W-1:0];
        ctrl.ord_idx  = ord_cnt_reg[DIM_W-1:0];
        ctrl.perm_idx = k_reg[DIM_W-1:0];
        ctrl.perm_val = DIM_W'(stat.order_ax);
        ctrl.k        = k_reg;
        ctrl.out_last = k_last;
        ctrl.first    = first_reg;
        ctrl.err_code = err_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    ctrl.load_en = room_ax;
                    ctrl.ord_en  = take_ord;
                    if (last_axis)
                    begin
                        // End of the array: freeze the counts and start checking.
                        n_next       = room_ax ? ax_cnt_reg + 1'b1 : ax_cnt_reg;
                        ng_next      = take_ord ? ord_cnt_reg + 1'b1 : ord_cnt_reg;
                        ax_cnt_next  = '0;
                        ord_cnt_next = '0;
                        k_next       = '0;
                        used_next    = '0;
                    end
                    else
                    begin
                        if (room_ax)
                            ax_cnt_next = ax_cnt_reg + 1'b1;
                        if (take_ord)
                            ord_cnt_next = ord_cnt_reg + 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                // One requested entry per cycle: range and repeat check.
                if (k_at_ng)
                begin
                    k_next = '0;
                    p_next = ng_reg;
                end
                else if (bad_axis)
                begin
                    err_next = ERR_AXIS;
                end
                else
                begin
                    used_next[stat.order_ax] = 1'b1;
                    ctrl.perm_wr = 1'b1;
                    k_next = k_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                // Append the axes not named, in ascending order.
                if (k_at_n)
                begin
                    k_next = '0;
                end
                else
                begin
                    if (!used_reg[k_reg[DIM_W-1:0]])
                    begin
                        ctrl.perm_wr  = 1'b1;
                        ctrl.perm_idx = p_reg[DIM_W-1:0];
                        ctrl.perm_val = k_reg[DIM_W-1:0];
                        p_next = p_reg + 1'b1;
                    end
                    k_next = k_reg + 1'b1;
                end
            end
            ST_VINIT:
            begin
                ctrl.vinit = 1'b1;
                ovf_next   = 1'b0;
                first_next = n_reg;
                k_next     = '0;
            end
            ST_VOL:
            begin
                // One prefix product per cycle through the shared multiplier.
                if (k_at_n)
                begin
                    k_next = '0;
                    if (ovf_reg)
                        err_next = ERR_OVF;
                end
                else
                begin
                    ctrl.vol_en = 1'b1;
                    if (stat.prod_ovf)
                        ovf_next = 1'b1;
                    if ((first_reg == n_reg) && stat.moved)
                        first_next = k_reg;
                    k_next = k_reg + 1'b1;
                end
            end
            ST_OUT_RD:
                ctrl.out_rd = 1'b1;
            ST_OUT_EM:
            begin
                ctrl.out_em = 1'b1;
                k_next = k_reg + 1'b1;
            end
            ST_ERR:
                ctrl.err_em = 1'b1;
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/core/arsc_dpath.sv]
`timescale 1ns / 1ps

module arsc_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  arsc_pkg::ctrl_t                     ctrl,
    input  logic [arsc_pkg::EXTENT_BITS-1:0]    extent,
    input  logic [arsc_pkg::AXIS_W-1:0]         order_axis,
    output arsc_pkg::status_t                   stat,
    output logic                                result_valid,
    output logic [15:0]                         new_extent,
    output logic signed [arsc_pkg::INC_W-1:0]   increment,
    output logic [3:0]                          first_moved,
    output logic [1:0]                          error,
    output logic                                last_result
);
    import arsc_pkg::*;

    // Small stores, one entry per axis.
    logic [EXTENT_BITS-1:0] ext_store [MAX_DIMS];
    logic [AXIS_W-1:0]      ord_store [MAX_DIMS];
    logic [DIM_W-1:0]       to_old    [MAX_DIMS];
    logic [DIM_W-1:0]       old_to_new[MAX_DIMS];

    // Prefix volume memory, two read ports.
    logic [VOL_W-1:0]       vol_mem [MAX_DIMS+1];

    logic [VOL_W-1:0]       acc_reg;
    logic [VOL_W-1:0]       va_reg;
    logic [VOL_W-1:0]       vb_reg;
    logic [EXTENT_BITS-1:0] ext_rd_reg;
    logic [DIM_W-1:0]       prev_reg;

    logic                   valid_reg;
    logic [15:0]            new_extent_reg;
    logic [INC_W-1:0]       increment_reg;
    logic [3:0]             first_moved_reg;
    logic [1:0]             error_reg;
    logic                   last_reg;

    logic [DIM_W-1:0]       kd;
    logic [DIM_W-1:0]       old_ax;
    logic [EXTENT_BITS-1:0] ext_sel;
    logic [PROD_W-1:0]      prod;
    logic [DIM_W-1:0]       pos_k;
    logic [CNT_W-1:0]       rd_b_addr;
    logic [CNT_W-1:0]       vol_wa;
    logic [INC_W-1:0]       inc_val;

    assign kd        = ctrl.k[DIM_W-1:0];
    assign old_ax    = to_old[kd];
    assign ext_sel   = ext_store[old_ax];
    assign prod      = PROD_W'(acc_reg) * PROD_W'(ext_sel);
    assign pos_k     = old_to_new[kd];
    assign rd_b_addr = CNT_W'(prev_reg) + 1'b1;
    assign vol_wa    = ctrl.k + 1'b1;

    // Status for the sequencer.
    assign stat.order_ax = ord_store[kd];
    assign stat.prod_ovf = |prod[PROD_W-1:VOL_W];
    assign stat.moved    = (old_ax != kd);

    // Axis stores and permutation tables.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
            ext_store[ctrl.load_idx] <= extent;
        if (ctrl.ord_en)
            ord_store[ctrl.ord_idx] <= order_axis;
        if (ctrl.perm_wr)
            to_old[ctrl.perm_idx] <= ctrl.perm_val;
        if (ctrl.vol_en)
            old_to_new[old_ax] <= kd;
    end

    // Running product and prefix volume memory.
    always_ff @(posedge clk)
    begin
        if (ctrl.vinit)
        begin
            acc_reg    <= VOL_W'(1);
            vol_mem[0] <= VOL_W'(1);
        end
        else if (ctrl.vol_en)
        begin
            acc_reg         <= prod[VOL_W-1:0];
            vol_mem[vol_wa] <= prod[VOL_W-1:0];
        end
        if (ctrl.out_rd)
        begin
            va_reg     <= vol_mem[CNT_W'(pos_k)];
            vb_reg     <= vol_mem[rd_b_addr];
            ext_rd_reg <= ext_sel;
            prev_reg   <= pos_k;
        end
    end

    // Destination increment: a volume for axis 0, a difference otherwise.
    assign inc_val = (ctrl.k == '0) ? {1'b0, va_reg}
                                    : ({1'b0, va_reg} - {1'b0, vb_reg});

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= ctrl.out_em || ctrl.err_em;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.err_em)
        begin
            new_extent_reg  <= '0;
            increment_reg   <= '0;
            first_moved_reg <= '0;
            error_reg       <= ctrl.err_code;
            last_reg        <= 1'b1;
        end
        else if (ctrl.out_em)
        begin
            new_extent_reg  <= 16'(ext_rd_reg);
            increment_reg   <= inc_val;
            first_moved_reg <= 4'(ctrl.first);
            error_reg       <= ERR_NONE;
            last_reg        <= ctrl.out_last;
        end
    end

    assign result_valid = valid_reg;
    assign new_extent   = new_extent_reg;
    assign increment    = increment_reg;
    assign first_moved  = first_moved_reg;
    assign error        = error_reg;
    assign last_result  = last_reg;

endmodule
